// ===== rtl/core/heightmap_triangle_height_query_macros.svh =====
// assertion macros used by the checker file of the height query block
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HTQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htq check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define HTQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htq check failed");

`endif

// ===== rtl/core/htq_pkg.sv =====
// shared constants, codes and stage types of the height query block
`timescale 1ns / 1ps

package htq_pkg;

  localparam int MaxRows    = 256;
  localparam int MaxCols    = 256;
  localparam int StoreDepth = MaxRows * MaxCols;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int BankDepth  = (StoreDepth + 1) / 2;
  localparam int BankAw     = StoreAw - 1;
  localparam int CellW      = $clog2(MaxRows > MaxCols ? MaxRows : MaxCols);
  localparam int FracW      = 16;
  localparam int QuotW      = CellW + FracW;
  localparam int DivSteps   = QuotW;
  localparam int RowW       = $clog2(MaxRows + 1);
  localparam int ColW       = $clog2(MaxCols + 1);
  localparam int CfgIdxW    = 3;

  localparam logic [FracW:0] OneQ = {1'b1, {FracW{1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CfgQuadX = 3'd0,
    CfgQuadY = 3'd1,
    CfgRows  = 3'd2,
    CfgCols  = 3'd3,
    CfgScale = 3'd4,
    CfgBase  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ActLoad  = 1'b0,
    ActQuery = 1'b1
  } act_e;

  // one word in flight through the divider
  typedef struct packed {
    logic               qry;
    logic               bad;
    logic [StoreAw-1:0] ld_addr;
    logic [7:0]         ld_h;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [CellW-1:0]   nx;
    logic [CellW-1:0]   ny;
    logic [QuotW-1:0]   qx;
    logic [QuotW-1:0]   qy;
  } htq_div_t;

  // word after the cell bound check and address build
  typedef struct packed {
    logic               qry;
    logic               bad;
    logic               lo;
    logic [FracW-1:0]   fx;
    logic [FracW-1:0]   fy;
    logic [StoreAw-1:0] base;
    logic [StoreAw-1:0] ld_addr;
    logic [7:0]         ld_h;
  } htq_addr_t;

  // sideband that travels next to the store read
  typedef struct packed {
    logic             bad;
    logic             lo;
    logic [FracW-1:0] fx;
    logic [FracW-1:0] fy;
  } htq_ip_t;

  typedef struct packed {
    logic [7:0] h0;
    logic [7:0] hr;
    logic [7:0] hb;
    logic [7:0] hbr;
  } htq_corners_t;

endpackage

// ===== rtl/core/htq_div_stage.sv =====
// one restoring divide step for both axes, registered
`timescale 1ns / 1ps

module htq_div_stage import htq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [31:0] qsx_i,
  input  logic [31:0] qsy_i,
  input  logic        vld_i,
  input  htq_div_t    d_i,
  output logic        vld_o,
  output htq_div_t    d_o
);

  logic [32:0] tx, ty;
  logic        gx, gy;
  htq_div_t    d_d, d_q;
  logic        vld_q;

  always_comb begin
    d_d  = d_i;
    tx   = {d_i.rx, d_i.nx[CellW-1]};
    ty   = {d_i.ry, d_i.ny[CellW-1]};
    gx   = tx >= {1'b0, qsx_i};
    gy   = ty >= {1'b0, qsy_i};
    d_d.rx = gx ? 32'(tx - {1'b0, qsx_i}) : tx[31:0];
    d_d.ry = gy ? 32'(ty - {1'b0, qsy_i}) : ty[31:0];
    d_d.nx = d_i.nx << 1;
    d_d.ny = d_i.ny << 1;
    d_d.qx = (d_i.qx << 1) | QuotW'(gx);
    d_d.qy = (d_i.qy << 1) | QuotW'(gy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q <= d_d;
    end
  end

  assign vld_o = vld_q;
  assign d_o   = d_q;

endmodule

// ===== rtl/core/htq_store.sv =====
// height store split in even and odd banks, four corner reads per cycle while re_i is high
`timescale 1ns / 1ps

module htq_store import htq_pkg::*; (
  input  logic               clk_i,
  input  logic               re_i,
  input  logic               we_i,
  input  logic [StoreAw-1:0] waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic [StoreAw-1:0] base_i,
  input  logic [ColW-1:0]    cols_i,
  output htq_corners_t       corners_o
);

  logic [7:0] mem_e [BankDepth];
  logic [7:0] mem_o [BankDepth];

  logic [StoreAw-1:0] a0, a1, a2, a3;
  logic [StoreAw-1:0] e0, e1, o0, o1;
  logic [7:0]         e0_q, e1_q, o0_q, o1_q;
  logic               p0_q, p2_q;

  // each pair (cell, next column) has one even and one odd address
  always_comb begin
    a0 = base_i;
    a1 = base_i + StoreAw'(1);
    a2 = base_i + StoreAw'(cols_i);
    a3 = a2 + StoreAw'(1);
    e0 = a0[0] ? a1 : a0;
    o0 = a0[0] ? a0 : a1;
    e1 = a2[0] ? a3 : a2;
    o1 = a2[0] ? a2 : a3;
  end

  always_ff @(posedge clk_i) begin
    if (we_i && !waddr_i[0]) begin
      mem_e[waddr_i[StoreAw-1:1]] <= wdata_i;
    end
    if (we_i && waddr_i[0]) begin
      mem_o[waddr_i[StoreAw-1:1]] <= wdata_i;
    end
    if (re_i) begin
      e0_q <= mem_e[e0[StoreAw-1:1]];
      e1_q <= mem_e[e1[StoreAw-1:1]];
      o0_q <= mem_o[o0[StoreAw-1:1]];
      o1_q <= mem_o[o1[StoreAw-1:1]];
      p0_q <= a0[0];
      p2_q <= a2[0];
    end
  end

  always_comb begin
    corners_o.h0  = p0_q ? o0_q : e0_q;
    corners_o.hb  = p0_q ? e0_q : o0_q;
    corners_o.hr  = p2_q ? o1_q : e1_q;
    corners_o.hbr = p2_q ? e1_q : o1_q;
  end

endmodule

// ===== rtl/core/htq_interp.sv =====
// barycentric blend, height scale, rounding and saturation in five stages
`timescale 1ns / 1ps

module htq_interp import htq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               vld_i,
  input  htq_ip_t            ip_i,
  input  htq_corners_t       corners_i,
  input  logic signed [23:0] scale_i,
  input  logic [31:0]        base_i,
  output logic               vld_o,
  output logic [31:0]        height_o,
  output logic               in_range_o
);

  localparam int WW     = FracW + 1;
  localparam int ProdW  = WW + 1 + 9;
  localparam int RawW   = ProdW + 1;
  localparam int RawPad = RawW - 8 - FracW;
  localparam int ScW    = RawW + 24;
  localparam int RndW   = ScW + 1;

  logic [4:0] v_q;

  // stage 1: pick triangle, weights and edge deltas
  logic [7:0]        a1_d, a1_q;
  logic signed [8:0] d1_d, d2_d, d1_q, d2_q;
  logic [WW-1:0]     w1_d, w2_d, w1_q, w2_q;
  logic              bad1_q;

  always_comb begin
    if (ip_i.lo) begin
      a1_d = corners_i.h0;
      d1_d = $signed({1'b0, corners_i.hr}) - $signed({1'b0, corners_i.h0});
      d2_d = $signed({1'b0, corners_i.hb}) - $signed({1'b0, corners_i.h0});
      w1_d = {1'b0, ip_i.fx};
      w2_d = {1'b0, ip_i.fy};
    end else begin
      a1_d = corners_i.hbr;
      d1_d = $signed({1'b0, corners_i.hb}) - $signed({1'b0, corners_i.hbr});
      d2_d = $signed({1'b0, corners_i.hr}) - $signed({1'b0, corners_i.hbr});
      w1_d = OneQ - {1'b0, ip_i.fx};
      w2_d = OneQ - {1'b0, ip_i.fy};
    end
  end

  // stage 2: the two weighted deltas
  logic signed [ProdW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic [7:0]              a2_q;
  logic                    bad2_q;

  assign p1_d = $signed({1'b0, w1_q}) * d1_q;
  assign p2_d = $signed({1'b0, w2_q}) * d2_q;

  // stage 3: raw height in Q8.16
  logic signed [RawW-1:0] raw_d, raw_q;
  logic                   bad3_q;

  assign raw_d = $signed({{RawPad{1'b0}}, a2_q, {FracW{1'b0}}}) + p1_q + p2_q;

  // stage 4: scale
  logic signed [ScW-1:0] sc_d, sc_q;
  logic                  bad4_q;

  assign sc_d = raw_q * scale_i;

  // stage 5: round half up, floor shift, saturate
  logic signed [RndW-1:0] rnd, sh;
  logic [RndW-32:0]       upper;
  logic [31:0]            sat;

  always_comb begin
    rnd   = RndW'(sc_q) + RndW'(1 << (FracW - 1));
    sh    = rnd >>> FracW;
    upper = sh[RndW-1:31];
    if (&upper || ~|upper) begin
      sat = sh[31:0];
    end else if (sh[RndW-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q       <= a1_d;
      d1_q       <= d1_d;
      d2_q       <= d2_d;
      w1_q       <= w1_d;
      w2_q       <= w2_d;
      bad1_q     <= ip_i.bad;
      p1_q       <= p1_d;
      p2_q       <= p2_d;
      a2_q       <= a1_q;
      bad2_q     <= bad1_q;
      raw_q      <= raw_d;
      bad3_q     <= bad2_q;
      sc_q       <= sc_d;
      bad4_q     <= bad3_q;
      height_o   <= bad4_q ? base_i : sat;
      in_range_o <= !bad4_q;
    end
  end

  assign vld_o = v_q[4];

endmodule

// ===== rtl/core/heightmap_triangle_height_query.sv =====
// top level of the heightmap triangle height query block
`timescale 1ns / 1ps

// Heightmap height query. A load word (tuser low) writes one byte sample into
// the store at load_address; a query word (tuser high) returns one result word
// with the barycentric height at world point (query_x, query_y), scaled by
// height_scale and saturated to Q16.16. Negative points, a zero quad size and
// cells whose right or lower neighbour leave the map return base_height with
// in_range low. One word enters per clock unless a result is stalled; each
// query passes one input stage, a 24-stage restoring divider (one quotient
// bit per stage, x and y side by side, 8 cell bits and 16 fraction bits), a
// bound check and address stage, one store read and five blend/scale stages.
// The store is split into even and odd address banks with two read ports each,
// so the four corners of a cell come out in the same cycle. Loads write the
// store in the read stage, so every query sees exactly the loads ahead of it.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
// The store needs no clearing pass: unwritten samples read as garbage.
// Configuration may only be written while the pipe is empty.
module heightmap_triangle_height_query import htq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [15:0] load_address, [23:16] load_height, [55:24] query_x, [87:56] query_y
  input  logic [87:0]        s_axis_tdata,
  // [0] action
  input  logic [0:0]         s_axis_tuser,
  // result words
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] height
  output logic [31:0]        m_axis_tdata,
  // [0] in_range
  output logic [0:0]         m_axis_tuser,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  // configuration registers
  logic [31:0]        qsx_q, qsy_q, base_q;
  logic [8:0]         rows_q, cols_q;
  logic signed [23:0] scale_q;
  logic [RowW-1:0]    rows_c;
  logic [ColW-1:0]    cols_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsx_q   <= 32'h0001_0000;
      qsy_q   <= 32'h0001_0000;
      rows_q  <= 9'd256;
      cols_q  <= 9'd256;
      scale_q <= -24'sd65536;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgQuadX: qsx_q   <= cfg_wdata_i;
        CfgQuadY: qsy_q   <= cfg_wdata_i;
        CfgRows:  rows_q  <= cfg_wdata_i[8:0];
        CfgCols:  cols_q  <= cfg_wdata_i[8:0];
        CfgScale: scale_q <= $signed(cfg_wdata_i[23:0]);
        CfgBase:  base_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sizes above the store geometry are clamped
  assign rows_c = (32'(rows_q) > 32'(MaxRows)) ? RowW'(MaxRows) : RowW'(rows_q);
  assign cols_c = (32'(cols_q) > 32'(MaxCols)) ? ColW'(MaxCols) : ColW'(cols_q);

  // one global advance: the pipe moves unless a result sits unaccepted
  logic adv;
  logic res_vld;

  assign adv           = !res_vld || m_axis_tready;
  assign s_axis_tready = adv;

  // input stage: unpack, range pre-check, divider seed
  logic [15:0] in_addr;
  logic [7:0]  in_h;
  logic [31:0] in_qx, in_qy;
  logic        in_qry, in_ld_ok;
  htq_div_t    s0_d, s0_q;
  logic        s0_vld_d, s0_vld_q;

  always_comb begin
    in_addr  = s_axis_tdata[15:0];
    in_h     = s_axis_tdata[23:16];
    in_qx    = s_axis_tdata[55:24];
    in_qy    = s_axis_tdata[87:56];
    in_qry   = (act_e'(s_axis_tuser[0]) == ActQuery);
    in_ld_ok = 32'(in_addr) < 32'(StoreDepth);
    s0_vld_d = s_axis_tvalid && (in_qry || in_ld_ok);

    s0_d.qry     = in_qry;
    // quotient must fit the cell bits, otherwise the cell is off the map
    s0_d.bad     = in_qx[31] || in_qy[31] || (qsx_q == '0) || (qsy_q == '0)
                || ({{(CellW + 1){1'b0}}, in_qx[30:0]} >= {qsx_q, {CellW{1'b0}}})
                || ({{(CellW + 1){1'b0}}, in_qy[30:0]} >= {qsy_q, {CellW{1'b0}}});
    s0_d.ld_addr = StoreAw'(in_addr);
    s0_d.ld_h    = in_h;
    s0_d.rx      = 32'(in_qx[30:0] >> CellW);
    s0_d.ry      = 32'(in_qy[30:0] >> CellW);
    s0_d.nx      = in_qx[CellW-1:0];
    s0_d.ny      = in_qy[CellW-1:0];
    s0_d.qx      = '0;
    s0_d.qy      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s0_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
    end
  end

  // divider chain: quotient of point * 2^16 by quad size, one bit per stage
  htq_div_t            div_pay [DivSteps+1];
  logic [DivSteps:0]   div_vld;

  assign div_pay[0] = s0_q;
  assign div_vld[0] = s0_vld_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    htq_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .qsx_i  (qsx_q),
      .qsy_i  (qsy_q),
      .vld_i  (div_vld[i]),
      .d_i    (div_pay[i]),
      .vld_o  (div_vld[i+1]),
      .d_o    (div_pay[i+1])
    );
  end

  // address stage: neighbour bound check, triangle pick, cell index
  htq_div_t                 dq;
  logic [CellW-1:0]         cx, cy;
  logic [FracW-1:0]         fx, fy;
  logic [FracW:0]           fsum;
  logic [CellW+ColW:0]      base_full;
  htq_addr_t                a_d, a_q;
  logic                     a_vld_q;

  always_comb begin
    dq        = div_pay[DivSteps];
    cx        = dq.qx[QuotW-1:FracW];
    cy        = dq.qy[QuotW-1:FracW];
    fx        = dq.qx[FracW-1:0];
    fy        = dq.qy[FracW-1:0];
    fsum      = {1'b0, fx} + {1'b0, fy};
    base_full = (CellW + ColW + 1)'(cx) * (CellW + ColW + 1)'(cols_c)
              + (CellW + ColW + 1)'(cy);

    a_d.qry     = dq.qry;
    a_d.bad     = dq.bad
               || ((32'(cx) + 32'd1) >= 32'(rows_c))
               || ((32'(cy) + 32'd1) >= 32'(cols_c));
    a_d.lo      = !fsum[FracW];
    a_d.fx      = fx;
    a_d.fy      = fy;
    a_d.base    = StoreAw'(base_full);
    a_d.ld_addr = dq.ld_addr;
    a_d.ld_h    = dq.ld_h;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= div_vld[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q <= a_d;
    end
  end

  // store stage: loads write, queries read four corners
  htq_corners_t corners;
  htq_ip_t      m_q;
  logic         m_vld_q;

  htq_store u_store (
    .clk_i     (clk_i),
    .re_i      (adv),
    .we_i      (adv && a_vld_q && !a_q.qry),
    .waddr_i   (a_q.ld_addr),
    .wdata_i   (a_q.ld_h),
    .base_i    (a_q.base),
    .cols_i    (cols_c),
    .corners_o (corners)
  );

  // loads end here; only queries go on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= a_vld_q && a_q.qry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q.bad <= a_q.bad;
      m_q.lo  <= a_q.lo;
      m_q.fx  <= a_q.fx;
      m_q.fy  <= a_q.fy;
    end
  end

  // blend, scale and output register
  logic [31:0] res_height;
  logic        res_in_range;

  htq_interp u_interp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .vld_i      (m_vld_q),
    .ip_i       (m_q),
    .corners_i  (corners),
    .scale_i    (scale_q),
    .base_i     (base_q),
    .vld_o      (res_vld),
    .height_o   (res_height),
    .in_range_o (res_in_range)
  );

  assign m_axis_tvalid   = res_vld;
  assign m_axis_tdata    = res_height;
  assign m_axis_tuser[0] = res_in_range;

endmodule

// ===== rtl/core/htq_checker.sv =====
// port-level checks for the height query block and their bind
`timescale 1ns / 1ps

`include "heightmap_triangle_height_query_macros.svh"

module htq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // an empty output register never holds back the input side
  `HTQ_ASSERT_IMP(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready)

  // a waiting result freezes the pipe, so no word may enter
  `HTQ_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // a stalled result word stays put
  `HTQ_ASSERT_NXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind heightmap_triangle_height_query htq_checker u_htq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
